// File: hdl/base64_encoder_line_wrap_core_assert.svh
// Assertion macros for the base64 line wrap encoder checker.
// Used by b64lw_checker.sv; needs nothing else.
`ifndef BASE64_ENCODER_LINE_WRAP_CORE_ASSERT_SVH
`define BASE64_ENCODER_LINE_WRAP_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define B64LW_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64lw checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is low.
`define B64LW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64lw checker: next-cycle property failed");

`endif

// File: hdl/b64lw_pkg.sv
// Shared types, constants and the alphabet function of the base64 encoder.
// No dependencies; imported by the front, queue, back and top modules.
`timescale 1ns / 1ps

package b64lw_pkg;

    // Line length, rounded down to a multiple of four characters
    localparam int LINE_CHARS = 64;
    localparam int LINE_LEN   = LINE_CHARS & ~3;
    localparam int COL_W      = 10;
    localparam logic [COL_W:0] LINE_LEN_V = (COL_W + 1)'(LINE_LEN);

    // Special character codes
    localparam logic [6:0] CH_PAD = 7'd61;
    localparam logic [6:0] CH_CR  = 7'd13;
    localparam logic [6:0] CH_LF  = 7'd10;

    // One closed group handed from front to back
    typedef struct packed {
        logic [23:0] group;
        logic [1:0]  nbytes;  // 1 to 3
        logic        last;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

    // Standard base64 alphabet
    function automatic logic [6:0] b64_char(input logic [5:0] v);
        logic [6:0] r;
        if (v < 6'd26) begin
            r = 7'd65 + {1'b0, v};
        end else if (v < 6'd52) begin
            r = 7'd97 + {1'b0, v} - 7'd26;
        end else if (v < 6'd62) begin
            r = 7'd48 + {1'b0, v} - 7'd52;
        end else if (v == 6'd62) begin
            r = 7'd43;
        end else begin
            r = 7'd47;
        end
        return r;
    endfunction

endpackage

// File: hdl/b64lw_byte_if.sv
// Input byte channel of the base64 encoder.
// No dependencies.
`timescale 1ns / 1ps

interface b64lw_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: hdl/b64lw_char_if.sv
// Output character channel of the base64 encoder.
// No dependencies.
`timescale 1ns / 1ps

interface b64lw_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       last_char;
    logic       end_of_message;

    modport source (output valid, output out_char, output last_char,
                    output end_of_message, input ready);
    modport sink   (input valid, input out_char, input last_char,
                    input end_of_message, output ready);
endinterface

// File: hdl/b64lw_cfg_if.sv
// Configuration write channel of the base64 encoder.
// No dependencies.
`timescale 1ns / 1ps

interface b64lw_cfg_if;
    logic valid;
    logic ready;
    logic no_line_breaks;

    modport source (output valid, output no_line_breaks, input ready);
    modport sink   (input valid, input no_line_breaks, output ready);
endinterface

// File: hdl/b64lw_cmd_fifo.sv
// Two-entry group queue between the front and back of the encoder.
// Depends on b64lw_pkg.
`timescale 1ns / 1ps

module b64lw_cmd_fifo
    import b64lw_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_full,
    output t_head o_head,
    input  logic  i_pop
);

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == 2'd2);
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && (r_count != 2'd0);

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.cmd   = r_mem[r_rptr];

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push.cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

// File: hdl/b64lw_front.sv
// Front end: accepts bytes and packs them into groups of up to three bytes.
// Depends on b64lw_pkg and b64lw_byte_if.
`timescale 1ns / 1ps

module b64lw_front
    import b64lw_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    b64lw_byte_if.sink    i_byte_ch,
    input  logic          i_full,
    output t_push         o_push
);

    logic [15:0] r_held;
    logic [1:0]  r_phase;
    logic [15:0] n_held;
    logic [1:0]  n_phase;

    logic        accept;
    logic        closes;
    logic [1:0]  phase;
    logic [23:0] joined;

    assign i_byte_ch.ready = !i_full;
    assign accept = i_byte_ch.valid && !i_full;
    assign phase  = (r_phase > 2'd2) ? 2'd2 : r_phase;
    assign closes = (phase == 2'd2) || i_byte_ch.last_byte;
    assign joined = {r_held, i_byte_ch.data_byte};

    // Left-align the group in 24 bits
    always_comb begin
        o_push.valid       = accept && closes;
        o_push.cmd.nbytes  = phase + 2'd1;
        o_push.cmd.last    = i_byte_ch.last_byte;
        case (phase)
            2'd0:    o_push.cmd.group = {i_byte_ch.data_byte, 16'd0};
            2'd1:    o_push.cmd.group = {joined[15:0], 8'd0};
            default: o_push.cmd.group = joined;
        endcase
    end

    // Group collection
    always_comb begin
        n_held  = r_held;
        n_phase = r_phase;
        if (accept) begin
            if (closes) begin
                n_held  = 16'd0;
                n_phase = 2'd0;
            end else begin
                n_held  = joined[15:0];
                n_phase = phase + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= 16'd0;
            r_phase <= 2'd0;
        end else begin
            r_held  <= n_held;
            r_phase <= n_phase;
        end
    end

endmodule

// File: hdl/b64lw_back.sv
// Back end: turns each group into characters, pads and line breaks.
// Depends on b64lw_pkg and b64lw_char_if.
`timescale 1ns / 1ps

module b64lw_back
    import b64lw_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_no_lb,
    input  t_head         i_head,
    output logic          o_pop,
    b64lw_char_if.source  o_char_ch
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CHAR = 2'd1;
    localparam logic [1:0] ST_CR   = 2'd2;
    localparam logic [1:0] ST_LF   = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [1:0]       r_idx, n_idx;
    logic [COL_W-1:0] r_col, n_col;
    t_cmd             r_cmd, n_cmd;
    logic             r_out_valid, n_out_valid;
    logic [6:0]       r_out_char;
    logic             r_last_char;
    logic             r_eom;

    logic             advance;
    logic             emit;
    logic [6:0]       e_char;
    logic             e_final;
    logic [COL_W-1:0] col_inc;
    logic [COL_W-1:0] col_n;
    logic             wrap;
    logic             brk;
    logic             trail;
    logic [5:0]       sextet;

    assign advance = !r_out_valid || o_char_ch.ready;

    // Pick the six bits for the current character
    always_comb begin
        case (r_idx)
            2'd0:    sextet = r_cmd.group[23:18];
            2'd1:    sextet = r_cmd.group[17:12];
            2'd2:    sextet = r_cmd.group[11:6];
            default: sextet = r_cmd.group[5:0];
        endcase
    end

    // Column tracking and break decisions
    assign col_inc = r_col + 1'b1;
    assign wrap    = ({1'b0, col_inc} >= LINE_LEN_V);
    assign brk     = wrap && !i_no_lb;
    assign col_n   = wrap ? '0 : col_inc;
    assign trail   = r_cmd.last && (col_n != '0) && !i_no_lb;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_col       = r_col;
        n_cmd       = r_cmd;
        o_pop       = 1'b0;
        emit        = 1'b0;
        e_char      = CH_PAD;
        e_final     = 1'b0;
        n_out_valid = r_out_valid && !o_char_ch.ready;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_head.cmd;
                    n_idx   = 2'd0;
                    n_state = ST_CHAR;
                end
            end
            ST_CHAR: begin
                if (advance) begin
                    emit   = 1'b1;
                    e_char = (r_idx > r_cmd.nbytes) ? CH_PAD : b64_char(sextet);
                    n_col  = (r_idx == 2'd3 && r_cmd.last) ? '0 : col_n;
                    if (brk) begin
                        n_state = ST_CR;
                    end else if (r_idx != 2'd3) begin
                        n_idx = r_idx + 2'd1;
                    end else if (trail) begin
                        n_state = ST_CR;
                    end else begin
                        n_state = ST_IDLE;
                        e_final = 1'b1;
                    end
                end
            end
            ST_CR: begin
                if (advance) begin
                    emit    = 1'b1;
                    e_char  = CH_CR;
                    n_state = ST_LF;
                end
            end
            ST_LF: begin
                if (advance) begin
                    emit   = 1'b1;
                    e_char = CH_LF;
                    if (r_idx == 2'd3) begin
                        e_final = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + 2'd1;
                        n_state = ST_CHAR;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (emit) begin
            n_out_valid = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= 2'd0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload: current group and output register
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        if (emit) begin
            r_out_char  <= e_char;
            r_last_char <= e_final;
            r_eom       <= e_final && r_cmd.last;
        end
    end

    assign o_char_ch.valid          = r_out_valid;
    assign o_char_ch.out_char       = r_out_char;
    assign o_char_ch.last_char      = r_last_char;
    assign o_char_ch.end_of_message = r_eom;

endmodule

// File: hdl/base64_encoder_line_wrap_core.sv
// Top level of the base64 encoder with CR LF line wrapping.
// Depends on b64lw_pkg, the channel interfaces, front, queue and back.
//
// Channel     Dir  Payload                                   Accept
// i_byte_ch   in   data_byte[7:0], last_byte                 valid && ready
// o_char_ch   out  out_char[6:0], last_char, end_of_message  valid && ready
// i_cfg_ch    in   no_line_breaks                            valid && ready
//
// A byte is taken every cycle while the two-entry group queue has room.
// Each group costs the back end a load step and then its four characters,
// plus CR and LF when a line break falls in it. The back end's one character
// per cycle, while the output is not stalled, plus its load step sets the rate.
// Reset is synchronous, active low; no clearing pass. Output stalls hold the
// output register and back up through the queue to the byte input.
`timescale 1ns / 1ps

module base64_encoder_line_wrap_core
    import b64lw_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    b64lw_byte_if.sink    i_byte_ch,
    b64lw_cfg_if.sink     i_cfg_ch,
    b64lw_char_if.source  o_char_ch
);

    logic  r_no_lb;
    t_push push;
    t_head head;
    logic  full;
    logic  pop;

    // Configuration register, always ready
    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_no_lb <= 1'b0;
        end else if (i_cfg_ch.valid) begin
            r_no_lb <= i_cfg_ch.no_line_breaks;
        end
    end

    b64lw_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_ch (i_byte_ch),
        .i_full    (full),
        .o_push    (push)
    );

    b64lw_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_head  (head),
        .i_pop   (pop)
    );

    b64lw_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_no_lb   (r_no_lb),
        .i_head    (head),
        .o_pop     (pop),
        .o_char_ch (o_char_ch)
    );

endmodule

// File: hdl/b64lw_checker.sv
// Port-level checker for the base64 encoder, bound to the top level.
// Depends on b64lw_pkg and base64_encoder_line_wrap_core_assert.svh.
`timescale 1ns / 1ps
`include "base64_encoder_line_wrap_core_assert.svh"

module b64lw_checker
    import b64lw_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [6:0] i_out_char,
    input logic       i_last_char,
    input logic       i_eom
);

    logic       stalled;
    logic       is_cr;
    logic       is_lf;
    logic       cr_taken;
    logic [8:0] out_bits;

    assign stalled  = i_out_valid && !i_out_ready;
    assign is_cr    = (i_out_char == CH_CR);
    assign is_lf    = (i_out_char == CH_LF);
    assign cr_taken = i_out_valid && i_out_ready && is_cr;
    assign out_bits = {i_out_char, i_last_char, i_eom};

    // A stalled character holds
    `B64LW_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, stalled, i_out_valid && $stable(out_bits))

    // Message end only on the final character of a run
    `B64LW_ASSERT_NOW(a_eom_last, i_clk, i_rst_n, i_out_valid && i_eom, i_last_char)

    // A taken CR is followed at once by LF, and never ends a run
    `B64LW_ASSERT_NEXT(a_cr_lf, i_clk, i_rst_n, cr_taken, i_out_valid && is_lf)
    `B64LW_ASSERT_NOW(a_cr_not_last, i_clk, i_rst_n, i_out_valid && is_cr, !i_last_char)

    // Nothing shown right after reset
    `B64LW_ASSERT_NOW(a_reset_quiet, i_clk, i_rst_n, $past(!i_rst_n), !i_out_valid)

endmodule

bind base64_encoder_line_wrap_core b64lw_checker u_b64lw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_char_ch.valid),
    .i_out_ready (o_char_ch.ready),
    .i_out_char  (o_char_ch.out_char),
    .i_last_char (o_char_ch.last_char),
    .i_eom       (o_char_ch.end_of_message)
);

// File: bench/base64_encoder_line_wrap_core_tb.sv
// Self-checking bench for base64_encoder_line_wrap_core: drives byte requests,
// predicts every output character and checks them in order against the block.
// Depends on b64lw_pkg, the three channel interfaces and the encoder RTL.
`timescale 1ns / 1ps

module base64_encoder_line_wrap_core_tb;
    import b64lw_pkg::*;

    localparam int CLK_HALF_NS   = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 16;
    localparam int TIMEOUT_NS    = 4_000_000;
    localparam int MAX_RUN       = 6;

    // One expected output character
    typedef struct packed {
        logic [6:0] ch;
        logic       run_end;
        logic       msg_end;
    } t_char_rec;

    logic clk;
    logic rst_n;

    b64lw_byte_if byte_ch();
    b64lw_cfg_if  cfg_ch();
    b64lw_char_if char_ch();

    base64_encoder_line_wrap_core uut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_byte_ch (byte_ch),
        .i_cfg_ch  (cfg_ch),
        .o_char_ch (char_ch)
    );

    // Encoder state mirror and line mode mirror
    logic [15:0] enc_held;
    logic [1:0]  enc_phase;
    logic [9:0]  enc_column;
    logic        mode_no_breaks;

    string     alphabet_str =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    t_char_rec expected_chars[$];

    int send_idle_pct;
    int recv_stall_pct;
    int recv_hold_cycles;
    int fail_count;

    // Clock
    initial begin
        clk = 1'b0;
        forever #(CLK_HALF_NS) clk = ~clk;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Character sink: long hold-off first, else random stalls
    initial begin
        char_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (recv_hold_cycles > 0) begin
                char_ch.ready <= 1'b0;
                recv_hold_cycles--;
            end else begin
                char_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Compare each accepted character with the oldest expectation
    always @(posedge clk) begin : char_check
        t_char_rec want;
        if (rst_n && char_ch.valid && char_ch.ready) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected char: out_char=%0d last_char=%0b end_of_message=%0b",
                       char_ch.out_char, char_ch.last_char, char_ch.end_of_message);
                fail_count++;
            end else begin
                want = expected_chars.pop_front();
                if (char_ch.out_char !== want.ch) begin
                    $error("out_char: expected %0d, got %0d", want.ch, char_ch.out_char);
                    fail_count++;
                end
                if (char_ch.last_char !== want.run_end) begin
                    $error("last_char: expected %0b, got %0b",
                           want.run_end, char_ch.last_char);
                    fail_count++;
                end
                if (char_ch.end_of_message !== want.msg_end) begin
                    $error("end_of_message: expected %0b, got %0b",
                           want.msg_end, char_ch.end_of_message);
                    fail_count++;
                end
            end
        end
    end

    // Work out the characters one accepted byte causes
    task automatic predict_encoding(input logic [7:0] b, input logic lst);
        logic [23:0] grp;
        logic [6:0]  c;
        t_char_rec   run_buf [MAX_RUN];
        int          n;
        int          nchars;
        n = 0;
        if (enc_phase < 2 && !lst) begin
            enc_held  = {enc_held[7:0], b};
            enc_phase = enc_phase + 2'd1;
            return;
        end
        grp    = {enc_held, b};
        grp    = grp << (8 * (2 - enc_phase));
        nchars = enc_phase + 2;
        for (int i = 0; i < 4; i++) begin
            if (i < nchars)
                c = 7'(alphabet_str[(grp >> (18 - 6 * i)) & 24'd63]);
            else
                c = CH_PAD;
            run_buf[n] = '{ch: c, run_end: 1'b0, msg_end: 1'b0};
            n = n + 1;
            enc_column = enc_column + 10'd1;
            if (enc_column >= LINE_LEN) begin
                enc_column = '0;
                if (!mode_no_breaks) begin
                    run_buf[n] = '{ch: CH_CR, run_end: 1'b0, msg_end: 1'b0};
                    n = n + 1;
                    run_buf[n] = '{ch: CH_LF, run_end: 1'b0, msg_end: 1'b0};
                    n = n + 1;
                end
            end
        end
        // trailing break closes a partial line
        if (lst) begin
            if (enc_column != 0 && !mode_no_breaks) begin
                run_buf[n] = '{ch: CH_CR, run_end: 1'b0, msg_end: 1'b0};
                n = n + 1;
                run_buf[n] = '{ch: CH_LF, run_end: 1'b0, msg_end: 1'b0};
                n = n + 1;
            end
            enc_column = '0;
        end
        enc_held  = '0;
        enc_phase = '0;
        run_buf[n-1].run_end = 1'b1;
        run_buf[n-1].msg_end = lst;
        for (int i = 0; i < n; i++) expected_chars.push_back(run_buf[i]);
    endtask

    // Offer one byte request, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= lst;
        @(posedge clk);
        while (!byte_ch.ready) @(posedge clk);
        predict_encoding(b, lst);
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) send_byte(8'($urandom_range(255)), i == len - 1);
    endtask

    // Stop sending and wait for every expected character, then let the front settle
    task automatic pause_until_drained();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_chars.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Line mode write, only after the output has drained
    task automatic write_line_mode(input logic nlb);
        pause_until_drained();
        cfg_ch.valid          <= 1'b1;
        cfg_ch.no_line_breaks <= nlb;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid   <= 1'b0;
        mode_no_breaks = nlb;
    endtask

    // Partial groups with padding, and alphabet corners
    task automatic test_group_sizes();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBE, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    // Breaks suppressed: no trailing CR LF either
    task automatic test_no_breaks();
        write_line_mode(1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hAB, 1'b0);
        send_byte(8'hCD, 1'b1);
        send_byte(8'h7F, 1'b1);
        write_line_mode(1'b0);
    endtask

    // Column keeps wrapping while breaks are off; mode flips mid-message with a byte held
    task automatic test_mode_switch_mid_message();
        write_line_mode(1'b1);
        for (int i = 0; i < 52; i++) send_byte(8'($urandom_range(255)), 1'b0);
        write_line_mode(1'b0);
        for (int i = 0; i < 44; i++) send_byte(8'($urandom_range(255)), i == 43);
    endtask

    // Sink holds off long enough for the block to stall its byte input
    task automatic test_output_backpressure();
        pause_until_drained();
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        recv_hold_cycles = 300;
        send_message(15);
        send_message(5);
        pause_until_drained();
    endtask

    // Random messages, mostly short, a few long ones cut to the budget
    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input logic nlb, input int budget);
        int sent;
        int len;
        write_line_mode(nlb);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(7) == 0)
                len = $urandom_range(100, 40);
            else
                len = $urandom_range(12, 1);
            if (len > budget - sent)
                len = budget - sent;
            send_message(len);
            sent += len;
        end
    endtask

    initial begin
        enc_held         = '0;
        enc_phase        = '0;
        enc_column       = '0;
        mode_no_breaks   = 1'b0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        recv_hold_cycles = 0;
        fail_count       = 0;

        rst_n                 <= 1'b0;
        byte_ch.valid         <= 1'b0;
        byte_ch.data_byte     <= '0;
        byte_ch.last_byte     <= 1'b0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.no_line_breaks <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_group_sizes();
        test_no_breaks();
        test_mode_switch_mid_message();
        test_output_backpressure();
        test_random_phase(0,  0,  1'b1, 12);
        test_random_phase(81, 0,  1'b0, 12);
        test_random_phase(0,  81, 1'b1, 12);
        test_random_phase(28, 28, 1'b0, 12);

        pause_until_drained();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: base64_encoder_line_wrap_core.f
+incdir+hdl
hdl/b64lw_pkg.sv
hdl/b64lw_byte_if.sv
hdl/b64lw_char_if.sv
hdl/b64lw_cfg_if.sv
hdl/b64lw_cmd_fifo.sv
hdl/b64lw_front.sv
hdl/b64lw_back.sv
hdl/base64_encoder_line_wrap_core.sv
hdl/b64lw_checker.sv
bench/base64_encoder_line_wrap_core_tb.sv
